// ===== hdl/vadpcm_pkg.sv =====
// shared types and constants of the vector adpcm frame decoder
`default_nettype none

package vadpcm_pkg;

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  shift;
    logic [3:0]  pred;
    logic [31:0] grp0;
    logic [31:0] grp1;
    logic [7:0]  idx;
    logic [15:0] coef;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_ORDER = 2'd1;

  localparam logic [4:0] COUNT_RESET = 5'd1;
  localparam logic [3:0] ORDER_RESET = 4'd2;
  localparam logic [3:0] ORDER_TWO   = 4'd2;

  localparam int unsigned Q_BITS = 11;
  localparam logic signed [31:0] SAMPLE_MAX = 32'sd32767;
  localparam logic signed [31:0] SAMPLE_MIN = -32'sd32768;

  localparam logic [2:0] POS_PREV = 3'd6;
  localparam logic [2:0] POS_LAST = 3'd7;

endpackage

`default_nettype wire

// ===== hdl/vadpcm_front.sv =====
// front end: takes items, drops frames that cannot decode, reduces the predictor number
`default_nettype none

module vadpcm_front #(
  parameter int unsigned MAX_PREDICTORS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             mode_i,
  input  wire logic [7:0]       header_byte_i,
  input  wire logic [31:0]      first_group_i,
  input  wire logic [31:0]      second_group_i,
  input  wire logic [7:0]       coef_index_i,
  input  wire logic [15:0]      coef_value_i,
  input  wire logic [4:0]       count_i,
  input  wire logic [3:0]       order_i,
  output logic                  push_valid_o,
  input  wire logic             push_ready_i,
  output vadpcm_pkg::cmd_t      push_data_o
);
  import vadpcm_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] fst_q, fst_d;
  cmd_t       cmd_q;
  logic [3:0] num_q;
  logic [3:0] rem_q;
  logic [1:0] step_q;
  logic       cfg_ok;
  logic       accept;
  logic [4:0] trial;
  logic [4:0] trial_red;

  assign cfg_ok = (count_i != 5'd0) && (32'(count_i) <= MAX_PREDICTORS) &&
                  (order_i == ORDER_TWO);
  assign accept = in_valid_i && in_ready_o;

  assign in_ready_o   = (fst_q == F_IDLE);
  assign push_valid_o = (fst_q == F_PUSH);
  assign push_data_o  = cmd_q;

  // one restoring step of header nibble mod count
  assign trial     = {rem_q, num_q[3]};
  assign trial_red = (trial >= count_i) ? (trial - count_i) : trial;

  always_comb begin
    fst_d = fst_q;
    case (fst_q)
      F_IDLE: begin
        if (accept) begin
          if (mode_i) begin
            fst_d = F_PUSH;
          end else if (cfg_ok) begin
            fst_d = F_MOD;
          end
        end
      end
      F_MOD: begin
        if (step_q == 2'd3) begin
          fst_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          fst_d = F_IDLE;
        end
      end
      default: fst_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q  <= F_IDLE;
      step_q <= 2'd0;
    end else begin
      fst_q <= fst_d;
      if (fst_q == F_MOD) begin
        step_q <= step_q + 2'd1;
      end else begin
        step_q <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.kind  <= mode_i ? CMD_WRITE : CMD_DECODE;
      cmd_q.shift <= header_byte_i[7:4];
      cmd_q.pred  <= 4'd0;
      cmd_q.grp0  <= first_group_i;
      cmd_q.grp1  <= second_group_i;
      cmd_q.idx   <= coef_index_i;
      cmd_q.coef  <= coef_value_i;
      num_q       <= header_byte_i[3:0];
      rem_q       <= 4'd0;
    end else if (fst_q == F_MOD) begin
      num_q <= {num_q[2:0], 1'b0};
      rem_q <= trial_red[3:0];
      if (step_q == 2'd3) begin
        cmd_q.pred <= trial_red[3:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vadpcm_queue.sv =====
// short command queue between front and back
`default_nettype none

module vadpcm_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire vadpcm_pkg::cmd_t  push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output vadpcm_pkg::cmd_t       pop_data_o
);
  import vadpcm_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            ent_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (32'(cnt_q) < QUEUE_DEPTH);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vadpcm_back.sv =====
// back end: predictor book memory, shared multiply-accumulate and sample output
`default_nettype none

module vadpcm_back #(
  parameter int unsigned MAX_PREDICTORS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  input  wire vadpcm_pkg::cmd_t  pop_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [15:0]     sample_o,
  output logic                   last_o
);
  import vadpcm_pkg::*;

  localparam int unsigned Depth = MAX_PREDICTORS * 16;
  localparam int unsigned AW    = $clog2(Depth);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_START = 2'd1;
  localparam logic [1:0] B_RUN   = 2'd2;
  localparam logic [1:0] B_DRAIN = 2'd3;

  logic [15:0] mem_q [Depth];

  logic [1:0]         bst_q;
  logic [3:0]         shift_q;
  logic [3:0]         pred_q;
  logic [31:0]        grp0_q;
  logic [31:0]        grp1_q;
  logic               g_q;
  logic [2:0]         i_q;
  logic [3:0]         t_q;
  logic signed [15:0] p0_q, p1_q, o6_q;
  logic signed [31:0] acc_q;
  logic signed [15:0] rd_q;
  logic signed [15:0] op_q;
  logic signed [31:0] prod_q;
  logic               v1_q, v2_q;
  logic               out_valid_q;
  logic signed [15:0] out_sample_q;
  logic               out_last_q;

  logic [31:0]        cur_grp;
  logic [15:0]        cur_res;
  logic [3:0]         tm2;
  logic [2:0]         k;
  logic [3:0]         pos;
  logic [7:0]         addr_full;
  logic signed [15:0] operand;
  logic               issue;
  logic               last_term;
  logic               fin;
  logic signed [31:0] scaled;
  logic signed [15:0] sat;
  logic               pop;

  function automatic logic [15:0] residual(input logic [31:0] grp, input logic [2:0] pos_n,
                                           input logic [3:0] shift);
    logic [3:0]  nib;
    logic [15:0] ext;
    nib = grp[{~pos_n, 2'b00} +: 4];
    ext = {{12{nib[3]}}, nib};
    return ext << shift;
  endfunction

  assign cur_grp   = g_q ? grp1_q : grp0_q;
  assign cur_res   = residual(cur_grp, i_q, shift_q);
  assign tm2       = t_q - 4'd2;
  assign k         = i_q - 3'd1 - tm2[2:0];
  assign issue     = (bst_q == B_RUN);
  assign last_term = (t_q == ({1'b0, i_q} + 4'd1));
  assign pop_ready_o = (bst_q == B_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign fin = (bst_q == B_DRAIN) && !v1_q && !v2_q && (!out_valid_q || out_ready_i);

  // term 0 is A[i]*p0, term 1 is B[i]*p1, then earlier residuals against B
  always_comb begin
    case (t_q)
      4'd0: begin
        pos     = {1'b0, i_q};
        operand = p0_q;
      end
      4'd1: begin
        pos     = {1'b1, i_q};
        operand = p1_q;
      end
      default: begin
        pos     = {1'b1, tm2[2:0]};
        operand = $signed(residual(cur_grp, k, shift_q));
      end
    endcase
  end

  assign addr_full = {pred_q, pos};

  assign scaled = acc_q >>> Q_BITS;
  always_comb begin
    if (scaled > SAMPLE_MAX) begin
      sat = SAMPLE_MAX[15:0];
    end else if (scaled < SAMPLE_MIN) begin
      sat = SAMPLE_MIN[15:0];
    end else begin
      sat = scaled[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (pop_data_i.kind == CMD_WRITE) && (32'(pop_data_i.idx) < Depth)) begin
      mem_q[pop_data_i.idx[AW-1:0]] <= pop_data_i.coef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= $signed(mem_q[addr_full[AW-1:0]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q       <= B_IDLE;
      g_q         <= 1'b0;
      i_q         <= 3'd0;
      t_q         <= 4'd0;
      p0_q        <= '0;
      p1_q        <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (bst_q)
        B_IDLE: begin
          if (pop && (pop_data_i.kind == CMD_DECODE)) begin
            g_q   <= 1'b0;
            i_q   <= 3'd0;
            bst_q <= B_START;
          end
        end
        B_START: begin
          t_q   <= 4'd0;
          bst_q <= B_RUN;
        end
        B_RUN: begin
          t_q <= t_q + 4'd1;
          if (last_term) begin
            bst_q <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (fin) begin
            if (i_q == POS_LAST) begin
              p0_q <= o6_q;
              p1_q <= sat;
              i_q  <= 3'd0;
              if (!g_q) begin
                g_q   <= 1'b1;
                bst_q <= B_START;
              end else begin
                bst_q <= B_IDLE;
              end
            end else begin
              i_q   <= i_q + 3'd1;
              bst_q <= B_START;
            end
          end
        end
        default: bst_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      shift_q <= pop_data_i.shift;
      pred_q  <= pop_data_i.pred;
      grp0_q  <= pop_data_i.grp0;
      grp1_q  <= pop_data_i.grp1;
    end
    op_q   <= operand;
    prod_q <= rd_q * op_q;
    if (bst_q == B_START) begin
      acc_q <= {{5{cur_res[15]}}, cur_res, 11'd0};
    end else if (v2_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (fin) begin
      out_sample_q <= sat;
      out_last_q   <= g_q && (i_q == POS_LAST);
      if (i_q == POS_PREV) begin
        o6_q <= sat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/vector_adpcm_frame_decoder.sv =====
// top level of the order-2 vector adpcm frame decoder
`default_nettype none

// Decodes one 9-byte frame per input beat into 16 PCM samples (last marks the
// sixteenth), or writes one Q11 predictor book coefficient when mode is 1.
// Frames are dropped without output when predictor_count is zero or above
// MAX_PREDICTORS, or when predictor_order is not two. The front end takes a
// beat, reduces the header's predictor number modulo the count by restoring
// steps and hands a command through a two-entry queue to the back end. The
// back end runs one shared 16x16 multiply-accumulate against a single-port
// book memory: sample i of a half frame needs i+2 products plus setup and
// drain. Book slots at or above MAX_PREDICTORS*16 are not stored.
module vector_adpcm_frame_decoder #(
  parameter int unsigned MAX_PREDICTORS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [4:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic [7:0]         header_byte_i,
  input  wire logic [31:0]        first_group_i,
  input  wire logic [31:0]        second_group_i,
  input  wire logic [7:0]         coef_index_i,
  input  wire logic signed [15:0] coef_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      sample_o,
  output logic                    last_o
);
  import vadpcm_pkg::*;

  logic [4:0] count_q;
  logic [3:0] order_q;
  logic       push_valid, push_ready;
  cmd_t       push_data;
  logic       pop_valid, pop_ready;
  cmd_t       pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      order_q <= ORDER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COUNT: count_q <= cfg_data_i;
        REG_ORDER: order_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  vadpcm_front #(
    .MAX_PREDICTORS(MAX_PREDICTORS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .header_byte_i  (header_byte_i),
    .first_group_i  (first_group_i),
    .second_group_i (second_group_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .count_i        (count_q),
    .order_i        (order_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  vadpcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  vadpcm_back #(
    .MAX_PREDICTORS(MAX_PREDICTORS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
